FILE: sv/yuvcc_pkg.sv
package yuvcc_pkg;

  localparam int CURVE_ENTRIES = 256;
  localparam int CURVE_AW      = $clog2(CURVE_ENTRIES);

  localparam logic        FUNC_PIXEL = 1'b0;
  localparam logic        FUNC_LOAD  = 1'b1;

  localparam logic [2:0]  CFG_MASTER_GAIN     = 3'd0;
  localparam logic [2:0]  CFG_SHADOW_GAIN     = 3'd1;
  localparam logic [2:0]  CFG_MIDTONE_GAIN    = 3'd2;
  localparam logic [2:0]  CFG_HIGHLIGHT_GAIN  = 3'd3;
  localparam logic [2:0]  CFG_SHADOW_LIMIT    = 3'd4;
  localparam logic [2:0]  CFG_HIGHLIGHT_LIMIT = 3'd5;

  localparam logic [15:0] GAIN_ONE        = 16'd4096;
  localparam logic [8:0]  SHADOW_LIM_RST  = 9'd64;
  localparam logic [7:0]  HILITE_LIM_RST  = 8'd191;

  localparam logic [23:0] W_R = 24'd19595;
  localparam logic [23:0] W_G = 24'd38470;
  localparam logic [23:0] W_B = 24'd7471;

  localparam logic signed [16:0] G_FROM_R = 17'sd33382;
  localparam logic signed [16:0] G_FROM_B = 17'sd12728;

  localparam logic [15:0] CURVE_MAX = 16'hFF00;

  localparam logic signed [57:0] DB_LIMIT = 58'sd14809538;
  localparam logic signed [57:0] DR_LIMIT = 58'sd11719137;

  localparam logic signed [26:0] BYTE_TOP = 27'sd16711680;

  typedef logic signed [24:0] diff_t;

  typedef struct packed {
    logic [15:0] master;
    logic [15:0] shadow;
    logic [15:0] midtone;
    logic [15:0] highlight;
    logic [8:0]  shadow_lim;
    logic [7:0]  highlight_lim;
  } gain_cfg_t;

  typedef struct packed {
    diff_t       db;
    diff_t       dr;
    logic [15:0] cv;
    logic        frame_end;
  } front_t;

  typedef struct packed {
    diff_t       db;
    diff_t       dr;
    logic [23:0] yn;
    logic        frame_end;
  } chroma_t;

  function automatic logic [7:0] to_byte(input logic signed [26:0] v);
    logic [7:0] res;
    if (v < 27'sd0) begin
      res = 8'd0;
    end else if (v > BYTE_TOP) begin
      res = 8'd255;
    end else begin
      res = v[23:16];
    end
    return res;
  endfunction

endpackage

FILE: sv/yuvcc_if.sv
interface yuvcc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_end_in;
  logic [7:0] curve_index;
  logic [15:0] curve_value;

  modport source (output valid, func, red_in, green_in, blue_in, frame_end_in,
                  curve_index, curve_value, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, frame_end_in,
                  curve_index, curve_value, output ready);
endinterface

interface yuvcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end_out;

  modport source (output valid, red_out, green_out, blue_out, frame_end_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end_out,
                  output ready);
endinterface

FILE: sv/yuv_color_correction_top.sv
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    func, red_in, green_in, blue_in, frame_end_in,
//                               curve_index, curve_value
// out_chan  out  valid/ready    red_out, green_out, blue_out, frame_end_out
// cfg_*     in   cfg_we         cfg_index, cfg_data
//
// One transaction per clock while out_chan is not stalled; a pixel passes through
// six register stages on its way to out_chan (curve read, gain product, two
// chroma scale stages, green products, output register).
// Curve loads write the curve when accepted and produce no output transaction.
// rst_n is synchronous; the 256-entry luma curve is not cleared and must be
// loaded before pixels that read it.
// Each stage holds when the next one is full and stalled; bubbles are absorbed.
module yuv_color_correction_top #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  yuvcc_in_if.sink    in_chan,
  yuvcc_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import yuvcc_pkg::*;

  gain_cfg_t cfg_r;
  gain_cfg_t cfg_nxt;
  front_t    s1;
  chroma_t   s2;
  logic      s1_valid;
  logic      s1_ready;
  logic      s2_valid;
  logic      s2_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASTER_GAIN:     cfg_nxt.master        = cfg_data;
        CFG_SHADOW_GAIN:     cfg_nxt.shadow        = cfg_data;
        CFG_MIDTONE_GAIN:    cfg_nxt.midtone       = cfg_data;
        CFG_HIGHLIGHT_GAIN:  cfg_nxt.highlight     = cfg_data;
        CFG_SHADOW_LIMIT:    cfg_nxt.shadow_lim    = cfg_data[8:0];
        CFG_HIGHLIGHT_LIMIT: cfg_nxt.highlight_lim = cfg_data[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master        <= GAIN_ONE;
      cfg_r.shadow        <= GAIN_ONE;
      cfg_r.midtone       <= GAIN_ONE;
      cfg_r.highlight     <= GAIN_ONE;
      cfg_r.shadow_lim    <= SHADOW_LIM_RST;
      cfg_r.highlight_lim <= HILITE_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  yuvcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn       (s1)
  );

  yuvcc_gain #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up       (s1),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn       (s2)
  );

  yuvcc_rebuild u_rebuild (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up       (s2),
    .out_chan (out_chan)
  );

  a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && (in_chan.func == FUNC_LOAD) |=> !s1_valid)
    else $error("curve load entered the pixel pipeline");

endmodule

FILE: sv/yuvcc_front.sv
module yuvcc_front (
  input  logic              clk,
  input  logic              rst_n,
  yuvcc_in_if.sink          in_chan,
  output logic              dn_valid,
  input  logic              dn_ready,
  output yuvcc_pkg::front_t dn
);
  import yuvcc_pkg::*;

  logic [CURVE_AW-1:0] code;
  logic [23:0]         ysum;
  logic [15:0]         wr_val;
  logic                adv;
  logic                load;
  logic                v_r;
  logic                v_nxt;
  diff_t               db_r;
  diff_t               dr_r;
  logic                fe_r;
  logic [15:0]         rd_r;
  logic [15:0]         curve_mem [CURVE_ENTRIES];

  assign adv   = !v_r || dn_ready;
  assign in_chan.ready = adv;
  assign load  = in_chan.valid && adv && (in_chan.func == FUNC_LOAD);
  assign v_nxt = in_chan.valid && (in_chan.func == FUNC_PIXEL);

  assign ysum = W_R * 24'(in_chan.red_in) + W_G * 24'(in_chan.green_in) +
                W_B * 24'(in_chan.blue_in);
  assign code = ysum[23:16];
  assign wr_val = (in_chan.curve_value > CURVE_MAX) ? CURVE_MAX : in_chan.curve_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      db_r <= $signed({1'b0, in_chan.blue_in, 16'h0000}) - $signed({1'b0, ysum});
      dr_r <= $signed({1'b0, in_chan.red_in, 16'h0000}) - $signed({1'b0, ysum});
      fe_r <= in_chan.frame_end_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      curve_mem[in_chan.curve_index] <= wr_val;
    end
    if (adv) begin
      rd_r <= curve_mem[code];
    end
  end

  assign dn_valid     = v_r;
  assign dn.db        = db_r;
  assign dn.dr        = dr_r;
  assign dn.cv        = rd_r;
  assign dn.frame_end = fe_r;

endmodule

FILE: sv/yuvcc_gain.sv
module yuvcc_gain #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  yuvcc_pkg::gain_cfg_t cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  yuvcc_pkg::front_t    up,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output yuvcc_pkg::chroma_t   dn
);
  import yuvcc_pkg::*;

  localparam int SHIFT = 2 * GAIN_FRAC_BITS;

  // stage A: zone gain product
  logic        va_r;
  logic [31:0] pa_r;
  diff_t       dba_r;
  diff_t       dra_r;
  logic [23:0] yna_r;
  logic        fea_r;
  // stage B: scaled differences
  logic                vb_r;
  logic signed [57:0]  pdb_r;
  logic signed [57:0]  pdr_r;
  logic [23:0]         ynb_r;
  logic                feb_r;
  // stage C: clamped differences
  logic        vc_r;
  diff_t       dbc_r;
  diff_t       drc_r;
  logic [23:0] ync_r;
  logic        fec_r;

  logic               adv_a;
  logic               adv_b;
  logic               adv_c;
  logic [7:0]         zcode;
  logic [15:0]        zone;
  logic signed [57:0] sdb;
  logic signed [57:0] sdr;
  logic signed [57:0] cdb;
  logic signed [57:0] cdr;

  assign adv_c    = !vc_r || dn_ready;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign up_ready = adv_a;

  assign zcode = up.cv[15:8];

  always_comb begin
    if ({1'b0, zcode} < cfg.shadow_lim) begin
      zone = cfg.shadow;
    end else if (zcode > cfg.highlight_lim) begin
      zone = cfg.highlight;
    end else begin
      zone = cfg.midtone;
    end
  end

  assign sdb = pdb_r >>> SHIFT;
  assign sdr = pdr_r >>> SHIFT;

  always_comb begin
    if (sdb > DB_LIMIT) begin
      cdb = DB_LIMIT;
    end else if (sdb < -DB_LIMIT) begin
      cdb = -DB_LIMIT;
    end else begin
      cdb = sdb;
    end
    if (sdr > DR_LIMIT) begin
      cdr = DR_LIMIT;
    end else if (sdr < -DR_LIMIT) begin
      cdr = -DR_LIMIT;
    end else begin
      cdr = sdr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= up_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
      if (adv_c) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      pa_r  <= 32'(cfg.master) * 32'(zone);
      dba_r <= up.db;
      dra_r <= up.dr;
      yna_r <= {up.cv, 8'h00};
      fea_r <= up.frame_end;
    end
    if (adv_b) begin
      pdb_r <= 58'(dba_r) * 58'($signed({1'b0, pa_r}));
      pdr_r <= 58'(dra_r) * 58'($signed({1'b0, pa_r}));
      ynb_r <= yna_r;
      feb_r <= fea_r;
    end
    if (adv_c) begin
      dbc_r <= cdb[24:0];
      drc_r <= cdr[24:0];
      ync_r <= ynb_r;
      fec_r <= feb_r;
    end
  end

  assign dn_valid     = vc_r;
  assign dn.db        = dbc_r;
  assign dn.dr        = drc_r;
  assign dn.yn        = ync_r;
  assign dn.frame_end = fec_r;

  a_db_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> ($signed(dbc_r) <= 25'sd14809538 && $signed(dbc_r) >= -25'sd14809538))
    else $error("clamped blue difference out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !dn_ready |=> vc_r && $stable(dbc_r) && $stable(drc_r))
    else $error("stalled chroma stage lost its item");

endmodule

FILE: sv/yuvcc_rebuild.sv
module yuvcc_rebuild (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  yuvcc_pkg::chroma_t up,
  yuvcc_out_if.source        out_chan
);
  import yuvcc_pkg::*;

  logic               vd_r;
  logic signed [41:0] gr_r;
  logic signed [41:0] gb_r;
  logic [7:0]         rd_r;
  logic [7:0]         bd_r;
  logic [23:0]        ynd_r;
  logic               fed_r;

  logic               ve_r;
  logic [7:0]         re_r;
  logic [7:0]         ge_r;
  logic [7:0]         be_r;
  logic               fee_r;

  logic               adv_d;
  logic               adv_e;
  logic signed [26:0] rp;
  logic signed [26:0] bp;
  logic signed [42:0] gsum;
  logic signed [42:0] gsh;
  logic signed [26:0] gp;

  assign adv_e    = !ve_r || out_chan.ready;
  assign adv_d    = !vd_r || adv_e;
  assign up_ready = adv_d;

  assign rp   = $signed({3'b000, up.yn}) + 27'(up.dr);
  assign bp   = $signed({3'b000, up.yn}) + 27'(up.db);
  assign gsum = 43'(gr_r) + 43'(gb_r);
  assign gsh  = gsum >>> 16;
  assign gp   = $signed({3'b000, ynd_r}) - gsh[26:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (adv_d) begin
        vd_r <= up_valid;
      end
      if (adv_e) begin
        ve_r <= vd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      gr_r  <= 42'(G_FROM_R) * 42'(up.dr);
      gb_r  <= 42'(G_FROM_B) * 42'(up.db);
      rd_r  <= to_byte(rp);
      bd_r  <= to_byte(bp);
      ynd_r <= up.yn;
      fed_r <= up.frame_end;
    end
    if (adv_e) begin
      re_r  <= rd_r;
      ge_r  <= to_byte(gp);
      be_r  <= bd_r;
      fee_r <= fed_r;
    end
  end

  assign out_chan.valid         = ve_r;
  assign out_chan.red_out       = re_r;
  assign out_chan.green_out     = ge_r;
  assign out_chan.blue_out      = be_r;
  assign out_chan.frame_end_out = fee_r;

endmodule
